// ===== rtl/mrh_pkg.sv =====
// Package for the four-lane multiply-rotate hash core.
// Holds the constants, FSM and handshake types, and the byte-piece helper
// functions. It depends on nothing else.
package mrh_pkg;

   localparam int unsigned LENGTH_BITS_DEFAULT = 32;

   // Mixing constants.
   localparam logic [63:0] K0 = 64'ha0761d6478bd642f;
   localparam logic [63:0] K1 = 64'he7037ed1a0b428db;
   localparam logic [63:0] K2 = 64'h8ebc6af09c88c6e3;
   localparam logic [63:0] K3 = 64'h589965cc75374cc3;
   localparam logic [63:0] K4 = 64'h1d8e4e27c47d124f;
   localparam logic [63:0] K5 = 64'heb44accab455d165;

   // Digit-serial multiplier geometry.
   localparam int unsigned DIGIT_BITS   = 4;
   localparam int unsigned MUL_STEPS    = 64 / DIGIT_BITS;
   localparam int unsigned MUL_CNT_BITS = $clog2(MUL_STEPS);

   // Configuration register map.
   localparam int unsigned CSR_ADDR_BITS = 2;
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_HASH_SEED  = 2'd0,
      CSR_SWAP_BYTES = 2'd1
   } csr_addr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BYTES,
      ST_GROUP,
      ST_MIX_A,
      ST_MIX_B,
      ST_FIN_TAIL,
      ST_FIN_A,
      ST_FIN_B,
      ST_FIN_C,
      ST_FIN_D,
      ST_OUT
   } state_type;

   // Request to and status from the shared multiplier.
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
      return (x << r) | (x >> (64 - r));
   endfunction

   function automatic logic [63:0] lane_mul_in(input logic [1:0] lane);
      logic [63:0] k;
      case (lane)
         2'd0:    k = K1;
         2'd1:    k = K2;
         2'd2:    k = K3;
         default: k = K4;
      endcase
      return k;
   endfunction

   function automatic logic [63:0] lane_mul_out(input logic [1:0] lane);
      logic [63:0] k;
      case (lane)
         2'd0:    k = K3;
         2'd1:    k = K4;
         2'd2:    k = K5;
         default: k = K1;
      endcase
      return k;
   endfunction

   function automatic logic [63:0] rotl_lane(input logic [63:0] x, input logic [1:0] lane);
      logic [63:0] y;
      case (lane)
         2'd0:    y = rotl(x, 27);
         2'd1:    y = rotl(x, 28);
         2'd2:    y = rotl(x, 30);
         default: y = rotl(x, 31);
      endcase
      return y;
   endfunction

   // Takes nb bytes from offset off of w, in the selected byte order.
   function automatic logic [63:0] piece(input logic [63:0] w, input logic [2:0] off,
                                         input logic [3:0] nb, input logic swap);
      logic [63:0] v;
      logic [2:0]  src;
      logic [2:0]  sh;
      v = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < nb) begin
            src = off + 3'(i);
            sh  = swap ? 3'(nb - 4'd1 - 4'(i)) : 3'(i);
            v[8*sh +: 8] = w[8*src +: 8];
         end
      end
      return v;
   endfunction

   // Packs a short tail of n bytes as 32-, 16- and 8-bit pieces, high first.
   function automatic logic [63:0] tail_pack(input logic [63:0] w, input logic [2:0] n,
                                             input logic swap);
      logic [63:0] v;
      logic [63:0] p;
      logic [2:0]  off;
      logic [2:0]  rem;
      v   = '0;
      off = 3'd0;
      rem = n;
      if (rem >= 3'd4) begin
         v   = piece(w, off, 4'd4, swap);
         off = 3'd4;
         rem = rem - 3'd4;
      end
      if (rem >= 3'd2) begin
         p   = piece(w, off, 4'd2, swap);
         v   = {v[47:0], p[15:0]};
         off = off + 3'd2;
         rem = rem - 3'd2;
      end
      if (rem >= 3'd1) begin
         p = piece(w, off, 4'd1, swap);
         v = {v[55:0], p[7:0]};
      end
      return v;
   endfunction

endpackage

// ===== rtl/mrh_ifs.sv =====
// Handshake channel interfaces for the hash core: input words, results and
// configuration writes. Depends on mrh_pkg for the register index width.
interface mrh_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_length;
   logic [63:0] data_word;
   logic [3:0]  valid_bytes;
   logic        last_word;
   modport source (output valid, message_length, data_word, valid_bytes, last_word,
                   input ready);
   modport sink (input valid, message_length, data_word, valid_bytes, last_word,
                 output ready);
endinterface

interface mrh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;
   modport source (output valid, hash_value, input ready);
   modport sink (input valid, hash_value, output ready);
endinterface

interface mrh_csr_if import mrh_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [CSR_ADDR_BITS-1:0] index;
   logic [63:0]              data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mrh_mul.sv =====
// Digit-serial 64 x 64 multiplier giving the low 64 product bits.
// One digit of the multiplier operand is consumed per cycle. Uses mrh_pkg.
module mrh_mul import mrh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mreq,
   output mul_rsp_type mrsp
);

   logic [63:0]             a_ff, a_in;
   logic [63:0]             b_ff, b_in;
   logic [63:0]             prod_ff, prod_in;
   logic [MUL_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [63:0]             digit_sum;

   // Partial product of a and the low digit of b, built from shifted copies of a.
   always_comb begin
      digit_sum = '0;
      for (int j = 0; j < DIGIT_BITS; j++) begin
         if (b_ff[j]) digit_sum = digit_sum + (a_ff << j);
      end
   end

   // Shift-and-add step: one digit of b times a per cycle.
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mreq.start) begin
         a_in    = mreq.a;
         b_in    = mreq.b;
         prod_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = prod_ff + digit_sum;
         a_in    = a_ff << DIGIT_BITS;
         b_in    = b_ff >> DIGIT_BITS;
         cnt_in  = cnt_ff + MUL_CNT_BITS'(1);
         if (cnt_ff == MUL_CNT_BITS'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign mrsp.busy    = busy_ff;
   assign mrsp.done    = done_ff;
   assign mrsp.product = prod_ff;

endmodule

// ===== rtl/four_lane_multiply_rotate_hash64_core.sv =====
// Four-lane multiply-rotate 64-bit hash core. A word is taken in ST_IDLE, then ST_BYTES packs one
// byte per cycle, pausing at each completed 8-byte group for ST_GROUP; a mixed group adds two
// serial multiplies on the 4-bit-per-cycle shared multiplier. The finish takes ST_FIN_TAIL plus
// ten such multiplies, after any pending group, then the result waits in a register; one message
// is in flight at a time.
// Synchronous active-high reset clears the sequencer, message state and both registers.
module four_lane_multiply_rotate_hash64_core import mrh_pkg::*; #(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   mrh_req_if.sink   req_chan,
   mrh_rsp_if.source rsp_chan,
   mrh_csr_if.sink   csr_chan
);

   localparam logic [LENGTH_BITS-1:0] GROUP_MASK  = ~LENGTH_BITS'(7);
   localparam logic [LENGTH_BITS-1:0] STRIPE_MASK = ~LENGTH_BITS'(31);

   state_type              state_ff, state_in;
   logic                   in_msg_ff, in_msg_in;
   logic [63:0]            seed_ff, seed_in;
   logic                   swap_ff, swap_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [63:0]            spl_ff, spl_in;
   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [63:0]            pend_ff, pend_in;
   logic [63:0]            acc_ff [4];
   logic [63:0]            acc_in [4];
   logic [63:0]            word_ff, word_in;
   logic [3:0]             nleft_ff, nleft_in;
   logic                   last_ff, last_in;
   logic [LENGTH_BITS-1:0] gstart_ff, gstart_in;
   logic [3:0]             gcnt_ff, gcnt_in;
   logic [1:0]             lane_ff, lane_in;
   logic                   fin_ff, fin_in;
   logic                   wait_ff, wait_in;
   logic [63:0]            x_ff, x_in;
   logic [63:0]            s_ff, s_in;

   mul_req_type            mreq;
   mul_rsp_type            mrsp;

   logic [LENGTH_BITS-1:0] len_new;
   logic [63:0]            s_new;
   logic [LENGTH_BITS-1:0] full_end;
   logic                   mixed;
   logic [1:0]             glane;
   logic [5:0]             total;
   logic [LENGTH_BITS-1:0] tail_diff;
   logic [3:0]             tail_cnt;
   logic [63:0]            hi4, lo4, split_rest, short_tail, prod;

   mrh_mul u_mul (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

   // Values derived from the held message state.
   always_comb begin
      len_new    = LENGTH_BITS'({32'd0, req_chan.message_length});
      s_new      = seed_ff + 64'(len_new);
      full_end   = len_ff & STRIPE_MASK;
      mixed      = ({1'b0, gstart_ff} + (LENGTH_BITS+1)'(8)) <= {1'b0, full_end};
      glane      = gstart_ff[4:3];
      total      = {1'b0, gstart_ff[4:0]} + 6'(gcnt_ff);
      tail_diff  = len_ff - (pos_ff & GROUP_MASK);
      tail_cnt   = (tail_diff > LENGTH_BITS'(8)) ? 4'd8 : tail_diff[3:0];
      hi4        = piece(pend_ff, 3'd0, 4'd4, swap_ff);
      lo4        = piece(pend_ff, 3'd4, 4'd4, swap_ff);
      split_rest = piece(pend_ff, 3'd4, 4'(total - 6'd20), swap_ff);
      short_tail = tail_pack(pend_ff, gcnt_ff[2:0], swap_ff);
      prod       = mrsp.product;
   end

   // Sequencer: byte packing, group processing and the finalizer.
   always_comb begin
      state_in  = state_ff;
      in_msg_in = in_msg_ff;
      seed_in   = seed_ff;
      swap_in   = swap_ff;
      len_in    = len_ff;
      spl_in    = spl_ff;
      pos_in    = pos_ff;
      pend_in   = pend_ff;
      for (int i = 0; i < 4; i++) acc_in[i] = acc_ff[i];
      word_in   = word_ff;
      nleft_in  = nleft_ff;
      last_in   = last_ff;
      gstart_in = gstart_ff;
      gcnt_in   = gcnt_ff;
      lane_in   = lane_ff;
      fin_in    = fin_ff;
      wait_in   = wait_ff;
      x_in      = x_ff;
      s_in      = s_ff;
      mreq.start = 1'b0;
      mreq.a     = '0;
      mreq.b     = '0;

      // Configuration writes.
      if (csr_chan.valid) begin
         unique case (csr_addr_type'(csr_chan.index))
            CSR_HASH_SEED:  seed_in = csr_chan.data;
            CSR_SWAP_BYTES: swap_in = csr_chan.data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (!in_msg_ff) begin
                  len_in    = len_new;
                  spl_in    = s_new;
                  acc_in[0] = rotl(s_new, 53) ^ K4;
                  acc_in[1] = rotl(s_new, 13) ^ K3;
                  acc_in[2] = rotl(s_new, 43) ^ K2;
                  acc_in[3] = rotl(s_new, 23) ^ K1;
                  pos_in    = '0;
                  pend_in   = '0;
                  in_msg_in = 1'b1;
               end
               word_in  = req_chan.data_word;
               nleft_in = (req_chan.valid_bytes > 4'd8) ? 4'd8 : req_chan.valid_bytes;
               last_in  = req_chan.last_word;
               state_in = ST_BYTES;
            end
         end
         ST_BYTES: begin
            // One byte per cycle into the pending group.
            if (nleft_ff != 4'd0 && pos_ff < len_ff) begin
               pend_in[8*pos_ff[2:0] +: 8] = word_ff[7:0];
               word_in  = word_ff >> 8;
               nleft_in = nleft_ff - 4'd1;
               pos_in   = pos_ff + LENGTH_BITS'(1);
               if (pos_ff[2:0] == 3'd7) begin
                  gstart_in = pos_ff & GROUP_MASK;
                  gcnt_in   = 4'd8;
                  fin_in    = 1'b0;
                  state_in  = ST_GROUP;
               end
            end else if (last_ff) begin
               state_in = ST_FIN_TAIL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIN_TAIL: begin
            s_in    = spl_ff ^ 64'(len_ff);
            lane_in = 2'd0;
            if (pos_ff[2:0] != 3'd0) begin
               gstart_in = pos_ff & GROUP_MASK;
               gcnt_in   = tail_cnt;
               fin_in    = 1'b1;
               state_in  = ST_GROUP;
            end else begin
               state_in = ST_FIN_A;
            end
         end
         ST_GROUP: begin
            if (mixed) begin
               lane_in  = glane;
               state_in = ST_MIX_A;
            end else begin
               // Tail bytes are added without mixing.
               if (gcnt_ff >= 4'd8) begin
                  acc_in[glane] = acc_ff[glane] + {hi4[31:0], lo4[31:0]};
               end else if (total == 6'd21 || total == 6'd22) begin
                  acc_in[2] = acc_ff[2] + hi4;
                  acc_in[3] = acc_ff[3] + split_rest;
               end else if (gcnt_ff != 4'd0) begin
                  acc_in[glane] = acc_ff[glane] + short_tail;
               end
               pend_in  = '0;
               state_in = fin_ff ? ST_FIN_A : ST_BYTES;
            end
         end
         ST_MIX_A: begin
            mreq.a = piece(pend_ff, 3'd0, 4'd8, swap_ff);
            mreq.b = lane_mul_in(lane_ff);
            if (!wait_ff) begin
               mreq.start = 1'b1;
               wait_in    = 1'b1;
            end else if (mrsp.done) begin
               wait_in  = 1'b0;
               x_in     = acc_ff[lane_ff] + prod;
               state_in = ST_MIX_B;
            end
         end
         ST_MIX_B: begin
            mreq.a = rotl_lane(x_ff, lane_ff);
            mreq.b = lane_mul_out(lane_ff);
            if (!wait_ff) begin
               mreq.start = 1'b1;
               wait_in    = 1'b1;
            end else if (mrsp.done) begin
               wait_in         = 1'b0;
               acc_in[lane_ff] = prod;
               pend_in         = '0;
               if (fin_ff) begin
                  lane_in  = 2'd0;
                  state_in = ST_FIN_A;
               end else begin
                  state_in = ST_BYTES;
               end
            end
         end
         ST_FIN_A: begin
            mreq.a = acc_ff[lane_ff];
            mreq.b = lane_mul_in(lane_ff);
            if (!wait_ff) begin
               mreq.start = 1'b1;
               wait_in    = 1'b1;
            end else if (mrsp.done) begin
               wait_in  = 1'b0;
               x_in     = prod;
               state_in = ST_FIN_B;
            end
         end
         ST_FIN_B: begin
            mreq.a = rotl_lane(x_ff, lane_ff);
            mreq.b = lane_mul_out(lane_ff);
            if (!wait_ff) begin
               mreq.start = 1'b1;
               wait_in    = 1'b1;
            end else if (mrsp.done) begin
               wait_in  = 1'b0;
               s_in     = s_ff ^ prod;
               lane_in  = lane_ff + 2'd1;
               state_in = (lane_ff == 2'd3) ? ST_FIN_C : ST_FIN_A;
            end
         end
         ST_FIN_C: begin
            mreq.a = s_ff;
            mreq.b = K0;
            if (!wait_ff) begin
               mreq.start = 1'b1;
               wait_in    = 1'b1;
            end else if (mrsp.done) begin
               wait_in  = 1'b0;
               s_in     = prod ^ rotl(prod, 23) ^ rotl(prod, 43);
               state_in = ST_FIN_D;
            end
         end
         ST_FIN_D: begin
            mreq.a = s_ff;
            mreq.b = K0;
            if (!wait_ff) begin
               mreq.start = 1'b1;
               wait_in    = 1'b1;
            end else if (mrsp.done) begin
               wait_in  = 1'b0;
               s_in     = prod ^ rotl(prod, 11) ^ rotl(prod, 50);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               in_msg_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         in_msg_ff <= 1'b0;
         seed_ff   <= '0;
         swap_ff   <= 1'b0;
         len_ff    <= '0;
         spl_ff    <= '0;
         pos_ff    <= '0;
         pend_ff   <= '0;
         for (int i = 0; i < 4; i++) acc_ff[i] <= '0;
         wait_ff   <= 1'b0;
         fin_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_msg_ff <= in_msg_in;
         seed_ff   <= seed_in;
         swap_ff   <= swap_in;
         len_ff    <= len_in;
         spl_ff    <= spl_in;
         pos_ff    <= pos_in;
         pend_ff   <= pend_in;
         for (int i = 0; i < 4; i++) acc_ff[i] <= acc_in[i];
         wait_ff   <= wait_in;
         fin_ff    <= fin_in;
      end
      word_ff   <= word_in;
      nleft_ff  <= nleft_in;
      last_ff   <= last_in;
      gstart_ff <= gstart_in;
      gcnt_ff   <= gcnt_in;
      lane_ff   <= lane_in;
      x_ff      <= x_in;
      s_ff      <= s_in;
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = (state_ff == ST_OUT);
   assign rsp_chan.hash_value = s_ff;

   // The multiplier is never restarted while it is still working.
   assert property (@(posedge clock) disable iff (reset) mreq.start |-> !mrsp.busy)
      else $error("multiplier started while busy");

   // The byte count never passes the declared length.
   assert property (@(posedge clock) disable iff (reset) pos_ff <= len_ff)
      else $error("byte position beyond message length");

   // A delivered hash closes the message.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_chan.valid && rsp_chan.ready |=> !in_msg_ff)
      else $error("message still open after result");

   // A word is never taken while a result is waiting.
   assert property (@(posedge clock) disable iff (reset)
                    req_chan.valid && req_chan.ready |-> !rsp_chan.valid)
      else $error("input accepted while result pending");

endmodule

// ===== dv/tb_four_lane_multiply_rotate_hash64_core.sv =====
// Self-checking testbench for the four-lane multiply-rotate hash core.
// Drives message words, checks each hash against a built-in predictor.
// Depends on mrh_pkg, the channel interfaces and the core.
module tb_four_lane_multiply_rotate_hash64_core;
   import mrh_pkg::*;

   logic clock;
   logic reset;

   mrh_req_if req_chan ();
   mrh_rsp_if rsp_chan ();
   mrh_csr_if csr_chan ();

   four_lane_multiply_rotate_hash64_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // Predictor state.
   logic [63:0] p_seed;
   logic        p_swap;
   logic [63:0] p_lane [4];
   logic [31:0] p_pos;
   logic [31:0] p_len;
   logic [63:0] p_spl;
   logic [63:0] p_tail;
   logic        p_busy;

   logic [63:0] expected_hashes [$];
   int          error_count;
   longint      cycle_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_off_cycles;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("ERROR %0t: %s", $time, what);
      error_count++;
   endtask

   function automatic logic [63:0] rot_left(input logic [63:0] x, input int r);
      if (r % 64 == 0) return x;
      return (x << (r % 64)) | (x >> (64 - r % 64));
   endfunction

   function automatic logic [63:0] mul_in_k(input int k);
      logic [63:0] t [4] = '{K1, K2, K3, K4};
      return t[k];
   endfunction

   function automatic logic [63:0] mul_out_k(input int k);
      logic [63:0] t [4] = '{K3, K4, K5, K1};
      return t[k];
   endfunction

   function automatic int rot_k(input int k);
      int t [4] = '{27, 28, 30, 31};
      return t[k];
   endfunction

   // Gathers nb bytes at offset off, byte-swapped when selected.
   function automatic logic [63:0] take_bytes(input logic [63:0] w, input int off, input int nb);
      logic [63:0] v;
      int          sh;
      v = '0;
      for (int i = 0; i < nb; i++) begin
         sh = p_swap ? (nb - 1 - i) : i;
         v[8*sh +: 8] = w[8*((off + i) % 8) +: 8];
      end
      return v;
   endfunction

   function automatic logic [63:0] pack_tail(input logic [63:0] w, input int n);
      logic [63:0] v;
      int          off;
      v = '0;
      off = 0;
      if (n >= 4) begin
         v = take_bytes(w, 0, 4);
         off = 4;
         n -= 4;
      end
      if (n >= 2) begin
         v = (v << 16) | take_bytes(w, off, 2);
         off += 2;
         n -= 2;
      end
      if (n >= 1) v = (v << 8) | take_bytes(w, off, 1);
      return v;
   endfunction

   // Folds one 8-byte group: full stripes mix, the tail adds unmixed.
   function automatic void fold_group(input logic [31:0] start, input logic [63:0] w,
                                      input int cnt);
      logic [31:0] full_end;
      logic [63:0] x;
      int          t;
      int          k;
      int          total;
      full_end = p_len & ~32'd31;
      if ({1'b0, start} + 33'd8 <= {1'b0, full_end}) begin
         k = start[4:3];
         x = p_lane[k] + take_bytes(w, 0, 8) * mul_in_k(k);
         p_lane[k] = rot_left(x, rot_k(k)) * mul_out_k(k);
      end else begin
         t = (start - full_end) & 31;
         k = (t >> 3) & 3;
         if (cnt >= 8) begin
            p_lane[k] += (take_bytes(w, 0, 4) << 32) | take_bytes(w, 4, 4);
         end else begin
            total = t + cnt;
            if (total == 21 || total == 22) begin
               p_lane[2] += take_bytes(w, 0, 4);
               p_lane[3] += take_bytes(w, 4, total - 20);
            end else if (cnt > 0) begin
               p_lane[k] += pack_tail(w, cnt);
            end
         end
      end
   endfunction

   function automatic logic [63:0] finish_hash();
      logic [63:0] s;
      logic [63:0] x;
      logic [31:0] start;
      logic [31:0] cnt;
      if (p_pos[2:0] != 0) begin
         start = p_pos - p_pos[2:0];
         cnt = p_len - start;
         if (cnt > 8) cnt = 8;
         fold_group(start, p_tail, cnt);
         p_tail = '0;
      end
      s = p_spl ^ {32'd0, p_len};
      for (int k = 0; k < 4; k++) begin
         x = p_lane[k] * mul_in_k(k);
         s ^= rot_left(x, rot_k(k)) * mul_out_k(k);
      end
      s *= K0;
      s ^= rot_left(s, 23) ^ rot_left(s, 43);
      s *= K0;
      s ^= rot_left(s, 11) ^ rot_left(s, 50);
      return s;
   endfunction

   // Applies one accepted word to the predictor.
   task automatic predict_word(input logic [31:0] len, input logic [63:0] w,
                               input logic [3:0] vb, input logic last);
      logic [63:0] s;
      int          n;
      if (!p_busy) begin
         p_len = len;
         s = p_seed + {32'd0, len};
         p_spl = s;
         p_lane[0] = rot_left(s, 53) ^ K4;
         p_lane[1] = rot_left(s, 13) ^ K3;
         p_lane[2] = rot_left(s, 43) ^ K2;
         p_lane[3] = rot_left(s, 23) ^ K1;
         p_pos = 0;
         p_tail = 0;
         p_busy = 1'b1;
      end
      n = (vb > 8) ? 8 : vb;
      for (int i = 0; i < n; i++) begin
         if (p_pos >= p_len) break;
         p_tail[8*p_pos[2:0] +: 8] = w[8*i +: 8];
         p_pos++;
         if (p_pos[2:0] == 0) begin
            fold_group(p_pos - 8, p_tail, 8);
            p_tail = '0;
         end
      end
      if (last) begin
         expected_hashes.push_back(finish_hash());
         p_busy = 1'b0;
      end
   endtask

   // Sends one word, idling at random beforehand; in this task valid drops only while idling.
   task automatic send_word(input logic [31:0] len, input logic [63:0] w,
                            input logic [3:0] vb, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.message_length <= len;
      req_chan.data_word      <= w;
      req_chan.valid_bytes    <= vb;
      req_chan.last_word      <= last;
      do @(posedge clock); while (!req_chan.ready);
      predict_word(len, w, vb, last);
   endtask

   // Sends a whole message of len bytes, in words of random fill when pieces_fill is set, else full words.
   task automatic send_message(input logic [31:0] len, input int pieces_fill);
      int left;
      int vb;
      left = len;
      if (len == 0) begin
         send_word(0, {$urandom, $urandom}, 4'($urandom_range(15)), 1'b1);
         return;
      end
      while (left > 0) begin
         vb = pieces_fill ? $urandom_range(1, 8) : 8;
         if ($urandom_range(19) == 0) vb = $urandom_range(9, 15);
         left -= (vb > 8) ? 8 : vb;
         send_word(len, {$urandom, $urandom}, 4'(vb), left <= 0);
      end
   endtask

   task automatic write_csr(input csr_addr_type idx, input logic [63:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (idx == CSR_HASH_SEED) p_seed = val;
      else p_swap = val[0];
      @(posedge clock);
   endtask

   // Waits until every expected hash has come back, then lets the core settle.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (expected_hashes.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_hashes.size() == 0) begin
            report_mismatch("unexpected hash");
         end else begin
            if (rsp_chan.hash_value !== expected_hashes[0])
               report_mismatch($sformatf("hash %h expected %h", rsp_chan.hash_value,
                                         expected_hashes[0]));
            void'(expected_hashes.pop_front());
         end
      end
   end

   // Receiver stalls, including long hold-off stretches.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic test_directed();
      int lens [] = '{0, 1, 7, 8, 9, 20, 21, 22, 31, 32, 33, 53, 54, 64, 100};
      foreach (lens[i]) send_message(lens[i], i % 2);
      // Short message: ends before declared length.
      send_word(40, 64'hffff_ffff_ffff_ffff, 4'd3, 1'b1);
      // Words past the declared length, then the end.
      send_word(3, 64'h0123_4567_89ab_cdef, 4'd8, 1'b0);
      send_word(3, 64'hffff_ffff_ffff_ffff, 4'd8, 1'b0);
      send_word(3, 64'hffff_ffff_ffff_ffff, 4'd0, 1'b1);
      // Huge declared length, few bytes.
      send_word(32'hffff_ffff, 64'h8000_0000_0000_0001, 4'd15, 1'b1);
      drain();
   endtask

   task automatic test_random(input int words);
      int sent;
      int len;
      sent = 0;
      while (sent < words) begin
         len = $urandom_range(0, 70);
         if ($urandom_range(9) == 0) begin
            send_word($urandom, {$urandom, $urandom}, 4'($urandom_range(15)), 1'b1);
            sent++;
         end else begin
            send_message(len, $urandom_range(1));
            sent += len / 6 + 1;
         end
      end
      drain();
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 3000;
      test_random(40);
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      hold_off_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      p_seed = '0;
      p_swap = 1'b0;
      p_busy = 1'b0;
      p_pos = 0;
      p_len = 0;
      p_tail = 0;
      p_spl = 0;
      req_chan.valid = 1'b0;
      req_chan.message_length = '0;
      req_chan.data_word = '0;
      req_chan.valid_bytes = '0;
      req_chan.last_word = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_HASH_SEED;
      csr_chan.data = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      write_csr(CSR_SWAP_BYTES, 64'd1);
      write_csr(CSR_HASH_SEED, 64'hffff_ffff_ffff_ffff);
      test_directed();
      send_idle_pct = 49;
      write_csr(CSR_HASH_SEED, {$urandom, $urandom});
      test_random(210);
      send_idle_pct = 0;
      recv_stall_pct = 49;
      write_csr(CSR_SWAP_BYTES, 64'd0);
      test_random(210);
      send_idle_pct = 10;
      recv_stall_pct = 10;
      write_csr(CSR_HASH_SEED, 64'd0);
      test_random(210);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_csr(CSR_SWAP_BYTES, 64'd1);
      test_random(170);
      test_backpressure();

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/mrh_pkg.sv
rtl/mrh_ifs.sv
rtl/mrh_mul.sv
rtl/four_lane_multiply_rotate_hash64_core.sv
dv/tb_four_lane_multiply_rotate_hash64_core.sv
